FILE: hdl/clme_pkg.sv
// ----------------------------------------------------------------------------
// clme_pkg: shared types and control program of the circular list move engine
// Holds the operation codes, the control word layout and the read-only
// program that steps the link datapath.
// ----------------------------------------------------------------------------
package clme_pkg;

    // reset value of the list size register, before clipping to MAX_NODES
    localparam int LIST_SIZE_RST = 1024;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_BEFORE = 2'd1,
        OP_AFTER  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    // operand sources for link memory addresses and write data
    typedef enum logic [2:0] {
        SRC_MV        = 3'd0,
        SRC_AN        = 3'd1,
        SRC_PD        = 3'd2,
        SRC_SD        = 3'd3,
        SRC_IDX       = 3'd4,
        SRC_INIT_SUCC = 3'd5,
        SRC_INIT_PRED = 3'd6
    } t_src;

    // sequencing conditions
    typedef enum logic [1:0] {
        C_NEXT  = 2'd0,
        C_END   = 2'd1,
        C_LOOP  = 2'd2,
        C_OPSEL = 2'd3
    } t_cond;

    typedef logic [3:0] t_step;

    // program entry points and steps
    localparam t_step ST_INIT     = 4'd0;
    localparam t_step ST_Q_RD     = 4'd1;
    localparam t_step ST_Q_OUT    = 4'd2;
    localparam t_step ST_MV_RD    = 4'd3;
    localparam t_step ST_UNLINK   = 4'd4;
    localparam t_step ST_RD_AN    = 4'd5;
    localparam t_step ST_B_LINK1  = 4'd6;
    localparam t_step ST_B_LINK2  = 4'd7;
    localparam t_step ST_A_LINK1  = 4'd8;
    localparam t_step ST_A_LINK2  = 4'd9;

    // control of one single-ported link memory
    typedef struct packed {
        logic en;
        logic we;
        t_src asel;
        t_src dsel;
    } t_port_ctl;

    // one control word
    typedef struct packed {
        t_port_ctl succ;
        t_port_ctl pred;
        logic      strobe;
        t_cond     cond;
        t_step     target;
    } t_uword;

    function automatic t_port_ctl port_rd(input t_src a);
        t_port_ctl p;
        p.en   = 1'b1;
        p.we   = 1'b0;
        p.asel = a;
        p.dsel = SRC_MV;
        return p;
    endfunction

    function automatic t_port_ctl port_wr(input t_src a, input t_src d);
        t_port_ctl p;
        p.en   = 1'b1;
        p.we   = 1'b1;
        p.asel = a;
        p.dsel = d;
        return p;
    endfunction

    function automatic t_port_ctl port_off();
        t_port_ctl p;
        p.en   = 1'b0;
        p.we   = 1'b0;
        p.asel = SRC_MV;
        p.dsel = SRC_MV;
        return p;
    endfunction

    // control program
    function automatic t_uword ucode_rom(input t_step s);
        t_uword w;
        w.succ   = port_off();
        w.pred   = port_off();
        w.strobe = 1'b0;
        w.cond   = C_END;
        w.target = ST_INIT;
        unique case (s)
            // ring rebuild, one node a step
            ST_INIT: begin
                w.succ   = port_wr(SRC_IDX, SRC_INIT_SUCC);
                w.pred   = port_wr(SRC_IDX, SRC_INIT_PRED);
                w.cond   = C_LOOP;
                w.target = ST_INIT;
            end
            // query: fetch both links of the anchor
            ST_Q_RD: begin
                w.succ = port_rd(SRC_AN);
                w.pred = port_rd(SRC_AN);
                w.cond = C_NEXT;
            end
            ST_Q_OUT: begin
                w.strobe = 1'b1;
                w.cond   = C_END;
            end
            // move: fetch the mover's neighbours
            ST_MV_RD: begin
                w.succ = port_rd(SRC_MV);
                w.pred = port_rd(SRC_MV);
                w.cond = C_NEXT;
            end
            // bridge the neighbours over the mover
            ST_UNLINK: begin
                w.succ = port_wr(SRC_PD, SRC_SD);
                w.pred = port_wr(SRC_SD, SRC_PD);
                w.cond = C_NEXT;
            end
            // fetch the anchor's links, then branch on direction
            ST_RD_AN: begin
                w.succ   = port_rd(SRC_AN);
                w.pred   = port_rd(SRC_AN);
                w.cond   = C_OPSEL;
                w.target = ST_A_LINK1;
            end
            // insert before the anchor
            ST_B_LINK1: begin
                w.succ = port_wr(SRC_PD, SRC_MV);
                w.pred = port_wr(SRC_MV, SRC_PD);
                w.cond = C_NEXT;
            end
            ST_B_LINK2: begin
                w.succ = port_wr(SRC_MV, SRC_AN);
                w.pred = port_wr(SRC_AN, SRC_MV);
                w.cond = C_END;
            end
            // insert after the anchor
            ST_A_LINK1: begin
                w.succ = port_wr(SRC_MV, SRC_SD);
                w.pred = port_wr(SRC_SD, SRC_MV);
                w.cond = C_NEXT;
            end
            ST_A_LINK2: begin
                w.succ = port_wr(SRC_AN, SRC_MV);
                w.pred = port_wr(SRC_MV, SRC_AN);
                w.cond = C_END;
            end
            default: begin
                w.cond = C_END;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/circular_list_move_engine.sv
// ----------------------------------------------------------------------------
// circular_list_move_engine: circular doubly linked ring of numbered nodes
// Successor and predecessor links live in two single-ported memories; a
// microcoded sequencer rebuilds the ring, relinks a node or answers a query.
// ----------------------------------------------------------------------------
// Steps: a query holds busy over its read and output steps, a move over its
//   mover read, unlink, anchor read and link steps; an init writes one node per
//   cycle up to the clipped list size; ignored words leave busy low. A word is
//   taken at any edge with busy low; results never stall. Reset: synchronous,
//   clears the sequencer and sets list_size to 1024, or to MAX_NODES if less;
//   the link memories are not cleared and hold nothing useful until an init.
module circular_list_move_engine #(
    parameter int MAX_NODES = 1024,
    localparam int NODE_W  = $clog2(MAX_NODES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [NODE_W-1:0] i_cfg_wdata,
    // command
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic [NODE_W-1:0] i_mover,
    input  logic [NODE_W-1:0] i_anchor,
    input  logic              i_forward,
    // result
    output logic              o_strobe,
    output logic [NODE_W-1:0] o_neighbor
);
    import clme_pkg::*;

    localparam logic [NODE_W-1:0] MAX_N    = NODE_W'(MAX_NODES);
    localparam logic [NODE_W-1:0] SIZE_RST =
        NODE_W'((MAX_NODES < LIST_SIZE_RST) ? MAX_NODES : LIST_SIZE_RST);
    localparam logic [NODE_W-1:0] ONE      = NODE_W'(1);

    // registers
    logic [NODE_W-1:0] r_list_size;
    logic              r_busy;
    t_step             r_pc;
    t_op               r_op;
    logic [NODE_W-1:0] r_mv;
    logic [NODE_W-1:0] r_an;
    logic              r_fw;
    logic [NODE_W-1:0] r_idx;
    logic [NODE_W-1:0] r_n;
    logic [NODE_W-1:0] r_sd;
    logic [NODE_W-1:0] r_pd;
    logic              r_strobe;
    logic [NODE_W-1:0] r_neighbor;
    logic [NODE_W-1:0] r_succ_mem [0:MAX_NODES];
    logic [NODE_W-1:0] r_pred_mem [0:MAX_NODES];

    // combinational
    logic [NODE_W-1:0] eff_size;
    logic              accept;
    logic              mv_ok;
    logic              an_ok;
    t_op               in_op;
    t_uword            ucode;
    logic [NODE_W-1:0] init_succ;
    logic [NODE_W-1:0] init_pred;
    logic [NODE_W-1:0] succ_addr;
    logic [NODE_W-1:0] succ_wdata;
    logic [NODE_W-1:0] pred_addr;
    logic [NODE_W-1:0] pred_wdata;

    function automatic logic [NODE_W-1:0] src_val(
        input t_src              s,
        input logic [NODE_W-1:0] mv,
        input logic [NODE_W-1:0] an,
        input logic [NODE_W-1:0] pd,
        input logic [NODE_W-1:0] sd,
        input logic [NODE_W-1:0] idx,
        input logic [NODE_W-1:0] isucc,
        input logic [NODE_W-1:0] ipred
    );
        logic [NODE_W-1:0] v;
        case (s)
            SRC_MV:        v = mv;
            SRC_AN:        v = an;
            SRC_PD:        v = pd;
            SRC_SD:        v = sd;
            SRC_IDX:       v = idx;
            SRC_INIT_SUCC: v = isucc;
            SRC_INIT_PRED: v = ipred;
            default:       v = mv;
        endcase
        return v;
    endfunction

    // size clipped to the memory depth, and node range checks
    assign eff_size = (r_list_size > MAX_N) ? MAX_N : r_list_size;
    assign mv_ok    = (i_mover != '0) && (i_mover <= eff_size);
    assign an_ok    = (i_anchor != '0) && (i_anchor <= eff_size);
    assign in_op    = t_op'(i_op);
    assign accept   = start && !r_busy;

    // control word of the current step
    assign ucode = ucode_rom(r_pc);

    // ring rebuild link values
    assign init_succ = (r_idx == r_n) ? ONE : r_idx + ONE;
    assign init_pred = (r_idx == ONE) ? r_n : r_idx - ONE;

    // memory address and data selection
    always_comb begin
        succ_addr  = src_val(ucode.succ.asel, r_mv, r_an, r_pd, r_sd, r_idx,
                             init_succ, init_pred);
        succ_wdata = src_val(ucode.succ.dsel, r_mv, r_an, r_pd, r_sd, r_idx,
                             init_succ, init_pred);
        pred_addr  = src_val(ucode.pred.asel, r_mv, r_an, r_pd, r_sd, r_idx,
                             init_succ, init_pred);
        pred_wdata = src_val(ucode.pred.dsel, r_mv, r_an, r_pd, r_sd, r_idx,
                             init_succ, init_pred);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_size <= SIZE_RST;
        end else if (i_cfg_we) begin
            r_list_size <= i_cfg_wdata;
        end
    end

    // sequencer: command capture, step counter and jumps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ST_INIT;
        end else if (accept) begin
            r_op  <= in_op;
            r_mv  <= i_mover;
            r_an  <= i_anchor;
            r_fw  <= i_forward;
            r_idx <= ONE;
            r_n   <= eff_size;
            case (in_op)
                OP_INIT: begin
                    r_busy <= (eff_size != '0);
                    r_pc   <= ST_INIT;
                end
                OP_QUERY: begin
                    r_busy <= an_ok;
                    r_pc   <= ST_Q_RD;
                end
                default: begin
                    r_busy <= mv_ok && an_ok && (i_mover != i_anchor);
                    r_pc   <= ST_MV_RD;
                end
            endcase
        end else if (r_busy) begin
            case (ucode.cond)
                C_NEXT: begin
                    r_pc <= r_pc + 4'd1;
                end
                C_LOOP: begin
                    if (r_idx == r_n) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_idx <= r_idx + ONE;
                        r_pc  <= ucode.target;
                    end
                end
                C_OPSEL: begin
                    r_pc <= (r_op == OP_AFTER) ? ucode.target : r_pc + 4'd1;
                end
                default: begin
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

    // successor link memory
    always_ff @(posedge i_clk) begin
        if (r_busy && ucode.succ.en) begin
            if (ucode.succ.we) begin
                r_succ_mem[succ_addr] <= succ_wdata;
            end else begin
                r_sd <= r_succ_mem[succ_addr];
            end
        end
    end

    // predecessor link memory
    always_ff @(posedge i_clk) begin
        if (r_busy && ucode.pred.en) begin
            if (ucode.pred.we) begin
                r_pred_mem[pred_addr] <= pred_wdata;
            end else begin
                r_pd <= r_pred_mem[pred_addr];
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_busy && ucode.strobe;
        end
        if (r_busy && ucode.strobe) begin
            r_neighbor <= r_fw ? r_sd : r_pd;
        end
    end

    assign busy       = r_busy;
    assign o_strobe   = r_strobe;
    assign o_neighbor = r_neighbor;

`ifndef SYNTHESIS
    // a result word only follows the output step of a query
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_busy && (r_pc == ST_Q_OUT)))
        else $error("result strobe without a query output step");

    // the step counter stays within the program while running
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= ST_A_LINK2))
        else $error("step counter beyond the program");

    // ring rebuild index stays within the captured size
    a_init_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_pc == ST_INIT)) |-> ((r_idx >= ONE) && (r_idx <= r_n)))
        else $error("init index out of range");

    // a query on node zero is dropped without starting the sequencer
    a_query_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_op == OP_QUERY) && (i_anchor == '0)) |=> !r_busy)
        else $error("out of range query started");

    // a move in progress always has distinct mover and anchor
    a_move_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_pc >= ST_MV_RD)) |-> (r_mv != r_an))
        else $error("move running with mover equal to anchor");
`endif

endmodule
